[design/sfh_pkg.sv]
// ----------------------------------------------------------------------------
// sfh_pkg
// shared types, constants and mixing functions of the streaming hash
// ----------------------------------------------------------------------------
`default_nettype none

package sfh_pkg;

    // word classes decided by the front end
    typedef enum logic [2:0] {
        KIND_EMPTY = 3'd0,
        KIND_TAIL1 = 3'd1,
        KIND_TAIL2 = 3'd2,
        KIND_TAIL3 = 3'd3,
        KIND_FULL  = 3'd4
    } word_kind_t;

    // queue between the front and back end
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic at_start;
    } front_stat_t;

    // map a byte count to its word class; counts of four or more are full words
    function automatic word_kind_t classify(input logic [2:0] cnt);
        word_kind_t k;
        case (cnt)
            3'd0:    k = KIND_EMPTY;
            3'd1:    k = KIND_TAIL1;
            3'd2:    k = KIND_TAIL2;
            3'd3:    k = KIND_TAIL3;
            default: k = KIND_FULL;
        endcase
        return k;
    endfunction

    // full word: mix low and high halves
    function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] h1;
        logic [31:0] t;
        logic [31:0] h2;
        h1 = h + {16'b0, w[15:0]};
        t  = {5'b0, w[31:16], 11'b0} ^ h1;
        h2 = {h1[15:0], 16'b0} ^ t;
        return h2 + {11'b0, h2[31:11]};
    endfunction

    // three byte tail, third byte sign extended
    function automatic logic [31:0] mix_tail3(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] s;
        logic [31:0] h3;
        h1 = h + {16'b0, w[15:0]};
        h2 = h1 ^ {h1[15:0], 16'b0};
        s  = {{24{w[23]}}, w[23:16]};
        h3 = h2 ^ {s[13:0], 18'b0};
        return h3 + {11'b0, h3[31:11]};
    endfunction

    // two byte tail
    function automatic logic [31:0] mix_tail2(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] h1;
        logic [31:0] h2;
        h1 = h + {16'b0, w[15:0]};
        h2 = h1 ^ {h1[20:0], 11'b0};
        return h2 + {17'b0, h2[31:17]};
    endfunction

    // single byte tail, byte sign extended
    function automatic logic [31:0] mix_tail1(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] h1;
        logic [31:0] h2;
        h1 = h + {{24{w[7]}}, w[7:0]};
        h2 = h1 ^ {h1[21:0], 10'b0};
        return h2 + {1'b0, h2[31:1]};
    endfunction

    // avalanche, first three steps
    function automatic logic [31:0] aval_first(input logic [31:0] h);
        logic [31:0] a;
        logic [31:0] b;
        a = h ^ {h[28:0], 3'b0};
        b = a + {5'b0, a[31:5]};
        return b ^ {b[27:0], 4'b0};
    endfunction

    // avalanche, last three steps
    function automatic logic [31:0] aval_second(input logic [31:0] h);
        logic [31:0] d;
        logic [31:0] e;
        d = h + {17'b0, h[31:17]};
        e = d ^ {d[6:0], 25'b0};
        return e + {6'b0, e[31:6]};
    endfunction

endpackage

`default_nettype wire

[design/sfh_if.sv]
// ----------------------------------------------------------------------------
// sfh_if
// message word channel and hash result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface sfh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic [31:0] total_length;

    modport source (output valid, data_word, byte_count, last_word, total_length,
                    input ready);
    modport sink   (input valid, data_word, byte_count, last_word, total_length,
                    output ready);
endinterface

interface sfh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

[design/sfh_front.sv]
// ----------------------------------------------------------------------------
// sfh_front
// accepts message words, classifies them and folds them into the running hash
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_front
    import sfh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sfh_in_if.sink           msg,
    input  wire q_stat_t     q_stat,
    output logic             push,
    output logic [31:0]      push_data,
    output front_stat_t      stat
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic        start_reg;
    logic        start_next;
    logic        accept;
    logic [31:0] seed;
    logic [31:0] mixed;
    word_kind_t  kind;

    // a beat is taken whenever the queue has room
    assign msg.ready = !q_stat.full;
    assign accept    = msg.valid && msg.ready;

    // seed from the length on the first word of a message
    assign seed = start_reg ? msg.total_length : hash_reg;
    assign kind = classify(msg.byte_count);

    // per-word mixing rule
    always_comb
    begin
        case (kind)
            KIND_FULL:  mixed = mix_word(seed, msg.data_word);
            KIND_TAIL3: mixed = mix_tail3(seed, msg.data_word);
            KIND_TAIL2: mixed = mix_tail2(seed, msg.data_word);
            KIND_TAIL1: mixed = mix_tail1(seed, msg.data_word);
            default:    mixed = seed;
        endcase
    end

    // next running state
    always_comb
    begin
        hash_next  = hash_reg;
        start_next = start_reg;
        if (accept)
        begin
            if (msg.last_word)
            begin
                hash_next  = 32'd0;
                start_next = 1'b1;
            end
            else
            begin
                hash_next  = mixed;
                start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= 32'd0;
            start_reg <= 1'b1;
        end
        else
        begin
            hash_reg  <= hash_next;
            start_reg <= start_next;
        end
    end

    // finished messages go to the back end
    assign push          = accept && msg.last_word;
    assign push_data     = mixed;
    assign stat.at_start = start_reg;

endmodule

`default_nettype wire

[design/sfh_queue.sv]
// ----------------------------------------------------------------------------
// sfh_queue
// short fifo of pre-avalanche hashes between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_queue
    import sfh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [31:0] push_data,
    input  wire logic        pop,
    output logic [31:0]      pop_data,
    output q_stat_t          stat
);

    logic [31:0]       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[design/sfh_back.sv]
// ----------------------------------------------------------------------------
// sfh_back
// two-stage avalanche pipeline; the second stage is the output register
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_back
    import sfh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire q_stat_t     q_stat,
    input  wire logic [31:0] pop_data,
    output logic             pop,
    sfh_out_if.source        hash
);

    logic        a_valid_reg;
    logic        a_valid_next;
    logic [31:0] a_hash_reg;
    logic        o_valid_reg;
    logic        o_valid_next;
    logic [31:0] o_hash_reg;
    logic        o_free;
    logic        a_free;
    logic        a_move;

    // elastic stage control
    assign o_free = !o_valid_reg || hash.ready;
    assign a_move = a_valid_reg && o_free;
    assign a_free = !a_valid_reg || o_free;
    assign pop    = !q_stat.empty && a_free;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        o_valid_next = o_valid_reg;
        if (a_free)
        begin
            a_valid_next = pop;
        end
        if (o_free)
        begin
            o_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // avalanche data path
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_hash_reg <= aval_first(pop_data);
        end
        if (a_move)
        begin
            o_hash_reg <= aval_second(a_hash_reg);
        end
    end

    assign hash.valid      = o_valid_reg;
    assign hash.hash_value = o_hash_reg;

endmodule

`default_nettype wire

[design/superfast_hash32.sv]
// ----------------------------------------------------------------------------
// superfast_hash32
// streaming 32-bit superfasthash over little-endian message words
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------
//  msg     | in  | data_word, byte_count, last_word, total_length
//  hash    | out | hash_value, one beat per message
//
//  one message word is taken every cycle while the queue has room; the per-word mix is combinational
//  the hash beat is offered after the last word's beat has passed through the
//  queue entry, first avalanche stage and output register
//  reset clears the running hash and arms the length seed for a new message
//  msg stalls only when the two-entry queue of finished hashes is full
// ----------------------------------------------------------------------------
`default_nettype none

module superfast_hash32
    import sfh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sfh_in_if.sink    msg,
    sfh_out_if.source hash
);

    logic        push;
    logic [31:0] push_data;
    logic        pop;
    logic [31:0] pop_data;
    q_stat_t     q_stat;
    front_stat_t f_stat;

    sfh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data),
        .stat      (f_stat)
    );

    sfh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    sfh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .hash     (hash)
    );

    // a finished message never arrives at a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("hash pushed into full queue");

    // the last word re-arms the length seed
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready && msg.last_word) |=> f_stat.at_start)
        else $error("seed not re-armed after last word");

    // a word that is not last continues the message
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready && !msg.last_word) |=> !f_stat.at_start)
        else $error("message start flag set mid-message");

    // the back end drains only what the queue holds
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
